[rtl/core/inr_pkg.sv]
package inr_pkg;

    // Field widths of the request and result transactions.
    localparam int ACTION_W = 2;
    localparam int MUT_W    = 3;
    localparam int GENE_W   = 2;
    localparam int NODE_W   = 10;
    localparam int KEY_W    = MUT_W + GENE_W + NODE_W + NODE_W;
    localparam int OUT_NUM_W = 24;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    // Widths of the restart arithmetic: product of two node counts and
    // the base value inputs plus outputs plus one.
    localparam int PROD_W = 2 * NODE_W;
    localparam int BASE_W = NODE_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    // Request action codes. Any code with bit 1 set is a restart.
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd1;
    localparam int ACT_RESTART_BIT = 1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_IN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_OUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the key, restart the scan pointer
        logic step;       // issue the next table read
        logic do_hit;     // take the matching entry as the result
        logic do_miss;    // insert, or flag a full table or counter limit
        logic do_clear;   // empty the table, keep the counter
        logic do_mul;     // multiply step of a restart
        logic do_restart; // add-and-saturate step of a restart
        logic load_out;   // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic scan_done;
    } t_dp_stat;

endpackage

[rtl/core/inr_ctrl.sv]
module inr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [inr_pkg::ACTION_W-1:0]  i_action,
    input  logic                          i_out_stall,
    input  inr_pkg::t_dp_stat             i_stat,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output inr_pkg::t_dp_cmd              o_cmd
);
    import inr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_SUM,
        S_DONE
    } t_state;

    t_state   r_state, n_state;
    logic     r_out_valid, n_out_valid;
    t_dp_cmd  w_cmd;
    logic     w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        w_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    if (i_action[ACT_RESTART_BIT]) begin
                        n_state = S_MUL;
                    end else if (i_action == ACT_CLEAR) begin
                        w_cmd.do_clear = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    w_cmd.do_hit = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.scan_done) begin
                    w_cmd.do_miss = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_cmd.step = 1'b1;
                end
            end
            S_MUL: begin
                w_cmd.do_mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                w_cmd.do_restart = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

[rtl/core/inr_dpath.sv]
module inr_dpath #(
    parameter int TABLE_DEPTH = 64,
    parameter int NUMBER_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [inr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [inr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [inr_pkg::MUT_W-1:0]       i_mutation_kind,
    input  logic [inr_pkg::GENE_W-1:0]      i_gene_kind,
    input  logic [inr_pkg::NODE_W-1:0]      i_source_node,
    input  logic [inr_pkg::NODE_W-1:0]      i_target_node,
    input  inr_pkg::t_dp_cmd                i_cmd,
    output inr_pkg::t_dp_stat               o_stat,
    output logic [inr_pkg::OUT_NUM_W-1:0]   o_innovation_number,
    output logic [inr_pkg::STATUS_W-1:0]    o_status
);
    import inr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = KEY_W + NUMBER_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [31:0] MAX32 = (32'd1 << NUMBER_BITS) - 32'd1;

    // Configuration registers.
    logic [NODE_W-1:0] r_num_in, r_num_out;
    logic              r_start;

    // Table memory: key in the upper bits, number in the lower bits.
    logic [EW-1:0]     r_mem [TABLE_DEPTH];
    logic [EW-1:0]     r_rd_data;
    logic              r_rd_vld;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_scan_idx;
    logic [NUMBER_BITS-1:0] r_next;
    logic [KEY_W-1:0]  r_key;

    logic [PROD_W-1:0] r_prod;
    logic [BASE_W-1:0] r_base;

    logic [NUMBER_BITS-1:0] r_res_num;
    logic [STATUS_W-1:0]    r_res_st;
    logic [OUT_NUM_W-1:0]   r_out_num;
    logic [STATUS_W-1:0]    r_out_st;

    logic              w_hit;
    logic              w_full;
    logic              w_at_max;
    logic              w_insert;
    logic              w_rd_en;
    logic [SUM_W-1:0]  w_sum;
    logic [31:0]       w_sum32;
    logic [NUMBER_BITS-1:0] w_restart_val;
    logic [31:0]       w_res32;

    assign w_hit    = r_rd_vld && (r_rd_data[EW-1 -: KEY_W] == r_key);
    assign w_full   = (r_count == DEPTH_C);
    assign w_at_max = (r_next == '1);
    assign w_insert = i_cmd.do_miss && !w_full && !w_at_max;
    assign w_rd_en  = i_cmd.step && (r_scan_idx < r_count);

    assign o_stat.hit       = w_hit;
    assign o_stat.scan_done = !r_rd_vld && (r_scan_idx == r_count);

    // Restart value with saturation at the counter limit.
    assign w_sum   = SUM_W'(r_prod) + SUM_W'(r_base);
    assign w_sum32 = 32'(w_sum);
    assign w_restart_val = (w_sum32 > MAX32) ? '1 : w_sum32[NUMBER_BITS-1:0];

    assign w_res32 = 32'(r_res_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_in  <= '0;
            r_num_out <= '0;
            r_start   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_IN:  r_num_in  <= i_cfg_data;
                CFG_NUM_OUT: r_num_out <= i_cfg_data;
                CFG_START:   r_start   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_mem[r_count[AW-1:0]] <= {r_key, r_next};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_scan_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_next     <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_scan_idx <= '0;
                r_rd_vld   <= 1'b0;
            end else if (i_cmd.step) begin
                r_rd_vld <= w_rd_en;
                if (w_rd_en) begin
                    r_scan_idx <= r_scan_idx + CW'(1);
                end
            end
            if (i_cmd.do_clear) begin
                r_count <= '0;
            end else if (i_cmd.do_restart) begin
                r_count <= '0;
                r_next  <= w_restart_val;
            end else if (w_insert) begin
                r_count <= r_count + CW'(1);
                r_next  <= r_next + NUMBER_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key <= {i_mutation_kind, i_gene_kind, i_source_node, i_target_node};
        end
        if (i_cmd.do_mul) begin
            r_prod <= r_start ? (PROD_W'(r_num_in) * PROD_W'(r_num_out)) : '0;
            r_base <= BASE_W'(r_num_in) + BASE_W'(r_num_out) + BASE_W'(1);
        end
        if (i_cmd.do_hit) begin
            r_res_num <= r_rd_data[NUMBER_BITS-1:0];
            r_res_st  <= ST_FOUND;
        end else if (i_cmd.do_miss) begin
            if (w_full) begin
                r_res_num <= '0;
                r_res_st  <= ST_FULL;
            end else if (w_at_max) begin
                r_res_num <= '0;
                r_res_st  <= ST_OVF;
            end else begin
                r_res_num <= r_next;
                r_res_st  <= ST_NEW;
            end
        end else if (i_cmd.do_clear) begin
            r_res_num <= r_next;
            r_res_st  <= ST_NEW;
        end else if (i_cmd.do_restart) begin
            r_res_num <= w_restart_val;
            r_res_st  <= ST_NEW;
        end
        if (i_cmd.load_out) begin
            r_out_num <= w_res32[OUT_NUM_W-1:0];
            r_out_st  <= r_res_st;
        end
    end

    assign o_innovation_number = r_out_num;
    assign o_status            = r_out_st;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C) else $error("entry count beyond table depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_idx <= r_count) else $error("scan pointer beyond entry count");

    a_miss_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_miss |-> !w_hit) else $error("miss taken while an entry matches");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not advance the entry count");
`endif

endmodule

[rtl/core/innovation_number_registry.sv]
// A lookup walks the table in a linear scan, one entry per cycle, through the table
// memory read port. A clear needs no scan; a restart multiplies, then adds and saturates.
// Throughput: one request at a time; the next request is accepted as soon as the
// previous result sits in the output register, even if that result is still stalled.
// Reset: synchronous active low; empties the table, zeroes the counter and config.
module innovation_number_registry #(
    parameter int TABLE_DEPTH = 64,
    parameter int NUMBER_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [inr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [inr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Request channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [inr_pkg::ACTION_W-1:0]    i_action,
    input  logic [inr_pkg::MUT_W-1:0]       i_mutation_kind,
    input  logic [inr_pkg::GENE_W-1:0]      i_gene_kind,
    input  logic [inr_pkg::NODE_W-1:0]      i_source_node,
    input  logic [inr_pkg::NODE_W-1:0]      i_target_node,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [inr_pkg::OUT_NUM_W-1:0]   o_innovation_number,
    output logic [inr_pkg::STATUS_W-1:0]    o_status
);
    import inr_pkg::*;

    // The controller sequences each transaction: it accepts a request only
    // when idle, walks the table with the datapath one entry per cycle, and
    // hands the finished result to the output register once that register
    // is free. The datapath owns the table memory, the entry count, the
    // running counter, the restart arithmetic and the result registers.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    inr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // The table is searched in insertion order; a miss appends the key at
    // the entry count with the current counter value, unless the table is
    // full or the counter has reached its maximum.
    inr_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUMBER_BITS (NUMBER_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_mutation_kind     (i_mutation_kind),
        .i_gene_kind         (i_gene_kind),
        .i_source_node       (i_source_node),
        .i_target_node       (i_target_node),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .o_innovation_number (o_innovation_number),
        .o_status            (o_status)
    );

endmodule

[tb/tb_innovation_number_registry.sv]
`timescale 1ns / 100ps

module tb_innovation_number_registry;
    import inr_pkg::*;

    // The block is built with its default table depth and counter width.
    // At 24 bits even the largest fully connected restart stays far below
    // the counter limit, so a miss never reports an overflow here.
    localparam int TABLE_DEPTH = 64;
    localparam int NUMBER_BITS = 24;
    localparam logic [NUMBER_BITS-1:0] COUNTER_TOP = {NUMBER_BITS{1'b1}};

    // The package names only the lookup and clear codes. Code 2 is the
    // restart, and code 3 also decodes as a restart because bit 1 is set.
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SPARE   = 2'd3;
    // Register index 3 has no register behind it, so writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_TARGET  = 650;
    localparam int CYCLE_LIMIT  = 600000;
    // A lookup scans at most the whole table; the settle time covers that scan.
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [MUT_W-1:0]    mutation_kind;
        logic [GENE_W-1:0]   gene_kind;
        logic [NODE_W-1:0]   source_node;
        logic [NODE_W-1:0]   target_node;
    } t_request;

    typedef struct packed {
        logic [OUT_NUM_W-1:0] number;
        logic [STATUS_W-1:0]  status;
    } t_result;

    typedef enum logic [1:0] {RX_RANDOM, RX_FREE, RX_HOLD} t_rx_mode;

    // The tracker keeps its own copy of the innovation table, the running
    // counter and the three configuration registers. For every accepted
    // request transaction it queues the result that the block must return.
    // Result transactions are then checked in order against that queue.
    class innovation_tracker;
        logic [KEY_W-1:0]       keys[TABLE_DEPTH];
        logic [NUMBER_BITS-1:0] numbers[TABLE_DEPTH];
        int unsigned            used;
        logic [NUMBER_BITS-1:0] counter;
        logic [NODE_W-1:0]      inputs_cfg;
        logic [NODE_W-1:0]      outputs_cfg;
        logic                   connected_cfg;
        t_result                awaited_results[$];
        int unsigned            mismatches;

        function new();
            used          = 0;
            counter       = '0;
            inputs_cfg    = '0;
            outputs_cfg   = '0;
            connected_cfg = 1'b0;
            mismatches    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NUM_IN:  inputs_cfg    = data[NODE_W-1:0];
                CFG_NUM_OUT: outputs_cfg   = data[NODE_W-1:0];
                CFG_START:   connected_cfg = data[0];
                default: ;
            endcase
        endfunction

        function t_result resolve_request(t_request r);
            logic [KEY_W-1:0]  key;
            longint unsigned   restart_value;
            t_result           res;

            // Any action with bit 1 set reloads the counter from the node counts.
            if (r.action[ACT_RESTART_BIT]) begin
                restart_value = longint'(inputs_cfg) + longint'(outputs_cfg) + 1;
                if (connected_cfg) begin
                    restart_value += longint'(inputs_cfg) * longint'(outputs_cfg);
                end
                if (restart_value > COUNTER_TOP) begin
                    restart_value = COUNTER_TOP;
                end
                used       = 0;
                counter    = restart_value[NUMBER_BITS-1:0];
                res.number = OUT_NUM_W'(counter);
                res.status = ST_NEW;
                return res;
            end
            if (r.action == ACT_CLEAR) begin
                used       = 0;
                res.number = OUT_NUM_W'(counter);
                res.status = ST_NEW;
                return res;
            end

            key = {r.mutation_kind, r.gene_kind, r.source_node, r.target_node};
            for (int i = 0; i < used; i++) begin
                if (keys[i] == key) begin
                    res.number = OUT_NUM_W'(numbers[i]);
                    res.status = ST_FOUND;
                    return res;
                end
            end
            // A full table is reported before a counter at its limit.
            res.number = '0;
            if (used == TABLE_DEPTH) begin
                res.status = ST_FULL;
                return res;
            end
            if (counter == COUNTER_TOP) begin
                res.status = ST_OVF;
                return res;
            end
            keys[used]    = key;
            numbers[used] = counter;
            used++;
            res.number    = OUT_NUM_W'(counter);
            res.status    = ST_NEW;
            counter++;
            return res;
        endfunction

        function void note_request(t_request r);
            awaited_results = {awaited_results, resolve_request(r)};
        endfunction

        function void check_result(logic [OUT_NUM_W-1:0] number, logic [STATUS_W-1:0] status);
            t_result expected;

            if (awaited_results.size() == 0) begin
                $error("unexpected result: innovation_number %0d, status %0d", number, status);
                mismatches++;
                return;
            end
            expected = awaited_results.pop_front();
            if (number !== expected.number) begin
                $error("innovation_number: expected %0d, actual %0d", expected.number, number);
                mismatches++;
            end
            if (status !== expected.status) begin
                $error("status: expected %0d, actual %0d", expected.status, status);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [ACTION_W-1:0]   i_action        = '0;
    logic [MUT_W-1:0]      i_mutation_kind = '0;
    logic [GENE_W-1:0]     i_gene_kind     = '0;
    logic [NODE_W-1:0]     i_source_node   = '0;
    logic [NODE_W-1:0]     i_target_node   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [OUT_NUM_W-1:0]  o_innovation_number;
    logic [STATUS_W-1:0]   o_status;

    innovation_tracker tracker;
    t_request          key_pool[$];
    t_rx_mode          rx_mode     = RX_RANDOM;
    bit                tx_idle     = 1'b1;
    int unsigned       items_sent  = 0;
    int unsigned       cycle_count = 0;

    innovation_number_registry #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .NUMBER_BITS(NUMBER_BITS)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_mutation_kind    (i_mutation_kind),
        .i_gene_kind        (i_gene_kind),
        .i_source_node      (i_source_node),
        .i_target_node      (i_target_node),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_innovation_number(o_innovation_number),
        .o_status           (o_status)
    );

    always #10 i_clk = ~i_clk;

    // The run is stopped here if results stop coming.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_innovation_number_registry: FAIL");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge. That is before any
    // nonblocking update of the same edge, so every value seen here is the
    // value that the block itself sees at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            tracker.note_request({i_action, i_mutation_kind, i_gene_kind,
                                  i_source_node, i_target_node});
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_innovation_number, o_status);
        end
    end

    // The result receiver normally stalls at random. It can also run free.
    // When asked, it holds off for a counted stretch. The sender keeps
    // offering transactions during that stretch, so the block backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_mode == RX_HOLD) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                while (rx_mode == RX_HOLD) @(posedge i_clk);
            end else begin
                i_out_stall <= (rx_mode == RX_RANDOM) && ($urandom_range(99) < 32);
            end
        end
    end

    // Offers one request transaction and returns right after the edge that
    // accepts it. Valid stays high when the next transaction follows at once.
    task automatic send_request(t_request r);
        int unsigned gap;

        gap = 0;
        if (tx_idle && $urandom_range(99) < 32) begin
            gap = $urandom_range(40, 1);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= r.action;
        i_mutation_kind <= r.mutation_kind;
        i_gene_kind     <= r.gene_kind;
        i_source_node   <= r.source_node;
        i_target_node   <= r.target_node;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic t_request fresh_lookup();
        t_request r;

        r.action        = ACT_LOOKUP;
        r.mutation_kind = MUT_W'($urandom());
        r.gene_kind     = GENE_W'($urandom());
        r.source_node   = NODE_W'($urandom());
        r.target_node   = NODE_W'($urandom());
        return r;
    endfunction

    task automatic send_key(logic [MUT_W-1:0] mutation, logic [GENE_W-1:0] gene,
                            logic [NODE_W-1:0] source, logic [NODE_W-1:0] target);
        send_request({ACT_LOOKUP, mutation, gene, source, target});
    endtask

    // For a clear or a restart, the key fields are random. The block must ignore them.
    task automatic send_command(logic [ACTION_W-1:0] action);
        t_request r;

        r        = fresh_lookup();
        r.action = action;
        send_request(r);
    endtask

    task automatic pause_until_drained(int unsigned settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.write_register(idx, data);
    endtask

    // Registers are only written once every result has come back.
    // The connected flag is written with random upper bits, which the block must ignore.
    task automatic configure(logic [NODE_W-1:0] inputs, logic [NODE_W-1:0] outputs,
                             logic connected, bit poke_spare);
        logic [CFG_DATA_W-1:0] flag_word;

        pause_until_drained(4);
        if (poke_spare) begin
            write_register(CFG_SPARE, CFG_DATA_W'($urandom()));
        end
        write_register(CFG_NUM_IN, inputs);
        write_register(CFG_NUM_OUT, outputs);
        flag_word    = CFG_DATA_W'($urandom());
        flag_word[0] = connected;
        write_register(CFG_START, flag_word);
        i_cfg_we <= 1'b0;
    endtask

    // Node counts lean toward small values, with the extremes mixed in.
    function automatic logic [NODE_W-1:0] pick_node_count();
        int unsigned roll;

        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        if (roll < 40) return NODE_W'($urandom());
        return NODE_W'($urandom_range(63));
    endfunction

    task automatic refill_pool(int unsigned size);
        key_pool.delete();
        repeat (size) key_pool = {key_pool, fresh_lookup()};
    endtask

    // Most lookups reuse a small pool of keys, so both hits and inserts are
    // common. Fresh keys, clears and restarts are mixed in between them.
    task automatic run_random_phase(int unsigned length, int unsigned pool_size);
        int unsigned pick;

        refill_pool(pool_size);
        repeat (length) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_command(ACT_CLEAR);
            end else if (pick < 9) begin
                send_command($urandom_range(1) ? ACT_RESTART : ACT_SPARE);
            end else if (pick < 25) begin
                send_request(fresh_lookup());
            end else begin
                send_request(key_pool[$urandom_range(key_pool.size() - 1)]);
            end
        end
    endtask

    initial begin
        int unsigned phase;

        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Start from the reset state: counter zero, no node counts.
        send_key(3'd0, 2'd0, 10'd0, 10'd0);
        send_key(3'd7, 2'd3, 10'd1023, 10'd1023);
        send_key(3'd0, 2'd0, 10'd0, 10'd0);
        send_key(3'd7, 2'd3, 10'd1023, 10'd1023);
        send_key(3'd5, 2'd2, 10'd682, 10'd341);
        send_command(ACT_CLEAR);
        send_key(3'd0, 2'd0, 10'd0, 10'd0);
        send_command(ACT_RESTART);
        send_command(ACT_SPARE);

        // A fully connected restart, two inserts and a hit, then a clear
        // that keeps the counter running for the next insert.
        configure(10'd45, 10'd88, 1'b1, 1'b1);
        send_command(ACT_RESTART);
        send_key(3'd2, 2'd1, 10'd100, 10'd200);
        send_key(3'd6, 2'd0, 10'd300, 10'd400);
        send_key(3'd2, 2'd1, 10'd100, 10'd200);
        send_command(ACT_CLEAR);
        send_key(3'd6, 2'd0, 10'd300, 10'd400);

        // The largest node counts, with and without a fully connected start.
        configure(10'd1023, 10'd1023, 1'b1, 1'b0);
        send_command(ACT_SPARE);
        send_key(3'd1, 2'd2, 10'd5, 10'd6);

        configure(10'd1023, 10'd1023, 1'b0, 1'b0);
        send_command(ACT_RESTART);
        send_key(3'd3, 2'd1, 10'd512, 10'd1);

        // Fill the table. After that, stored keys still hit and every miss
        // reports a full table.
        configure(10'd28, 10'd138, 1'b1, 1'b0);
        send_command(ACT_RESTART);
        refill_pool(TABLE_DEPTH);
        foreach (key_pool[i]) send_request(key_pool[i]);
        repeat (24) begin
            if ($urandom_range(1)) send_request(key_pool[$urandom_range(TABLE_DEPTH - 1)]);
            else send_request(fresh_lookup());
        end
        send_command(ACT_CLEAR);
        send_request(fresh_lookup());

        // Random phases. Each one starts once every result has come back.
        // Phase 1 holds the receiver off while the sender keeps going.
        // Phase 2 is a long stretch where neither side idles.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < 3 || $urandom_range(1)) begin
                configure(pick_node_count(), pick_node_count(), 1'($urandom_range(1)),
                          $urandom_range(3) == 0);
            end else begin
                pause_until_drained(4);
            end
            if ($urandom_range(99) < 70) send_command($urandom_range(1) ? ACT_RESTART : ACT_SPARE);
            else send_command(ACT_CLEAR);

            if (phase == 1) begin
                rx_mode <= RX_HOLD;
                run_random_phase(40, 30);
                rx_mode <= RX_RANDOM;
            end else if (phase == 2) begin
                tx_idle = 1'b0;
                rx_mode <= RX_FREE;
                run_random_phase(120, 90);
                tx_idle = 1'b1;
                rx_mode <= RX_RANDOM;
            end else begin
                run_random_phase($urandom_range(110, 20), $urandom_range(100, 4));
            end
            phase++;
        end

        pause_until_drained(DRAIN_CYCLES);
        if (tracker.mismatches == 0) begin
            $display("tb_innovation_number_registry: PASS");
        end else begin
            $display("tb_innovation_number_registry: FAIL");
        end
        $finish;
    end

endmodule
